@@ rtl/wsfd_pkg.sv @@
package wsfd_pkg;

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_PAY  = 3'd4;
  localparam logic [2:0] PH_DROP = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_HDR   = 2'd2;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [2:0] CNT_EXT16 = 3'd1;
  localparam logic [2:0] CNT_EXT64 = 3'd7;
  localparam logic [2:0] CNT_KEY   = 3'd3;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       fin;
    logic [3:0] opcode;
    logic       masked;
    logic [1:0] status;
    logic       last;
  } res_t;

endpackage

@@ rtl/wsfd_parse.sv @@
module wsfd_parse import wsfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] data_byte_i,
  input  logic       chunk_last_i,
  output logic       emit_o,
  output res_t       res_o
);

  logic [2:0]  phase_q, phase_d;
  logic [2:0]  phase_count_q, phase_count_d;
  logic        fin_q, fin_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        masked_q, masked_d;
  logic [63:0] payload_len_q, payload_len_d;
  logic [31:0] mask_key_q, mask_key_d;
  logic [63:0] payload_seen_q, payload_seen_d;

  logic [63:0] seen_inc;
  logic [7:0]  key_byte;
  logic        done;
  logic        valid;
  logic        emit;
  logic [1:0]  status;
  logic [7:0]  pbyte;

  assign seen_inc = payload_seen_q + 64'd1;

  always_comb begin
    case (payload_seen_q[1:0])
      2'd0:    key_byte = mask_key_q[31:24];
      2'd1:    key_byte = mask_key_q[23:16];
      2'd2:    key_byte = mask_key_q[15:8];
      default: key_byte = mask_key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d        = phase_q;
    phase_count_d  = phase_count_q;
    fin_d          = fin_q;
    opcode_d       = opcode_q;
    masked_d       = masked_q;
    payload_len_d  = payload_len_q;
    mask_key_d     = mask_key_q;
    payload_seen_d = payload_seen_q;
    done           = 1'b0;
    valid          = 1'b0;
    pbyte          = 8'd0;

    case (phase_q)
      PH_HDR0: begin
        fin_d          = data_byte_i[7];
        opcode_d       = data_byte_i[3:0];
        masked_d       = 1'b0;
        payload_len_d  = 64'd0;
        mask_key_d     = 32'd0;
        payload_seen_d = 64'd0;
        phase_d        = PH_HDR1;
      end
      PH_HDR1: begin
        masked_d      = data_byte_i[7];
        payload_len_d = 64'd0;
        if (data_byte_i[6:0] == LEN_EXT16) begin
          phase_d       = PH_EXT;
          phase_count_d = CNT_EXT16;
        end else if (data_byte_i[6:0] == LEN_EXT64) begin
          phase_d       = PH_EXT;
          phase_count_d = CNT_EXT64;
        end else begin
          payload_len_d = {57'd0, data_byte_i[6:0]};
          if (data_byte_i[7]) begin
            phase_d       = PH_KEY;
            phase_count_d = CNT_KEY;
          end else if (data_byte_i[6:0] == 7'd0) begin
            phase_d = PH_DROP;
            done    = 1'b1;
          end else begin
            phase_d = PH_PAY;
          end
        end
      end
      PH_EXT: begin
        payload_len_d = {payload_len_q[55:0], data_byte_i};
        if (phase_count_q == 3'd0) begin
          if (masked_q) begin
            phase_d       = PH_KEY;
            phase_count_d = CNT_KEY;
          end else if (payload_len_d == 64'd0) begin
            phase_d = PH_DROP;
            done    = 1'b1;
          end else begin
            phase_d = PH_PAY;
          end
        end else begin
          phase_count_d = phase_count_q - 3'd1;
        end
      end
      PH_KEY: begin
        mask_key_d = {mask_key_q[23:0], data_byte_i};
        if (phase_count_q == 3'd0) begin
          if (payload_len_q == 64'd0) begin
            phase_d = PH_DROP;
            done    = 1'b1;
          end else begin
            phase_d = PH_PAY;
          end
        end else begin
          phase_count_d = phase_count_q - 3'd1;
        end
      end
      PH_PAY: begin
        pbyte          = data_byte_i ^ key_byte;
        valid          = 1'b1;
        payload_seen_d = seen_inc;
        if (seen_inc >= payload_len_q) begin
          phase_d = PH_DROP;
          done    = 1'b1;
        end
      end
      default: begin
      end
    endcase

    emit   = valid || done;
    status = ST_OK;
    if (!done && chunk_last_i && phase_d != PH_DROP && phase_d <= PH_PAY) begin
      emit   = 1'b1;
      status = (phase_d == PH_PAY) ? ST_SHORT : ST_HDR;
    end

    if (chunk_last_i) begin
      phase_d       = PH_HDR0;
      phase_count_d = 3'd0;
    end
  end

  assign emit_o             = emit;
  assign res_o.payload_byte = pbyte;
  assign res_o.byte_valid   = valid;
  assign res_o.fin          = fin_d;
  assign res_o.opcode       = opcode_d;
  assign res_o.masked       = masked_d;
  assign res_o.status       = status;
  assign res_o.last         = done || (status != ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HDR0;
      phase_count_q  <= 3'd0;
      fin_q          <= 1'b0;
      opcode_q       <= 4'd0;
      masked_q       <= 1'b0;
      payload_len_q  <= 64'd0;
      mask_key_q     <= 32'd0;
      payload_seen_q <= 64'd0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      phase_count_q  <= phase_count_d;
      fin_q          <= fin_d;
      opcode_q       <= opcode_d;
      masked_q       <= masked_d;
      payload_len_q  <= payload_len_d;
      mask_key_q     <= mask_key_d;
      payload_seen_q <= payload_seen_d;
    end
  end

endmodule

@@ rtl/websocket_frame_deframer.sv @@
// Channel  Direction  Handshake             Beat
// in       input      in_valid_i/in_ready_o data_byte_i, chunk_last_i
// out      output     out_valid_o/out_ready_i payload_byte_o, byte_valid_o, fin_o,
//                                           opcode_o, masked_o, status_o, last_o
// One input beat per cycle while in_ready_o is high; its result, if any, is registered into the output or skid entry.
// Header parse, 64-bit length compare and key XOR are combinational after the
// frame state registers.
// Reset returns the parser to the first header byte and empties the output.
// A two-entry output register and skid stage keep in_ready_o high while the
// skid entry is empty; in_ready_o drops only when both entries hold results.
module websocket_frame_deframer import wsfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       chunk_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] payload_byte_o,
  output logic       byte_valid_o,
  output logic       fin_o,
  output logic [3:0] opcode_o,
  output logic       masked_o,
  output logic [1:0] status_o,
  output logic       last_o
);

  logic accept;
  logic emit;
  logic push;
  logic drain;
  res_t res;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  wsfd_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .data_byte_i  (data_byte_i),
    .chunk_last_i (chunk_last_i),
    .emit_o       (emit),
    .res_o        (res)
  );

  assign push  = accept && emit;
  assign drain = out_valid_q && out_ready_i;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || drain) begin
      if (skid_valid_q) begin
        out_d = skid_q;
      end else begin
        out_d = res;
      end
      out_valid_d  = skid_valid_q || push;
      skid_valid_d = 1'b0;
    end else if (push) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = out_q.payload_byte;
  assign byte_valid_o   = out_q.byte_valid;
  assign fin_o          = out_q.fin;
  assign opcode_o       = out_q.opcode;
  assign masked_o       = out_q.masked;
  assign status_o       = out_q.status;
  assign last_o         = out_q.last;

endmodule

@@ rtl/wsfd_chk.sv @@
module wsfd_chk import wsfd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] payload_byte_o,
  input logic       byte_valid_o,
  input logic [1:0] status_o,
  input logic       last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(payload_byte_o)
      && $stable(last_o) && $stable(status_o))
    else $error("output beat changed while stalled");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> payload_byte_o == 8'd0)
    else $error("empty beat carries nonzero byte");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> last_o)
    else $error("empty beat not marked last");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> last_o)
    else $error("error status without last");

  a_data_not_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> status_o != ST_HDR)
    else $error("payload byte flagged as header cut off");

endmodule

bind websocket_frame_deframer wsfd_chk u_wsfd_chk (.*);
